// ----- sv/dasm_pkg.sv -----
// Shared types, constants and profile tables for the DBPSK amplitude-shaped modulator.
// No dependencies; every other file imports this package.
`default_nettype none

package dasm_pkg;

  localparam int MAX_FRAME_BYTES = 32;
  localparam int PROFILE_STEPS   = 40;
  localparam int TABLE_LEN       = 40;

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = 5;
  localparam int LEN_W   = 6;
  localparam int LEVEL_W = 7;
  localparam int POS_W   = $clog2(PROFILE_STEPS + 1);
  localparam int ADDR_W  = $clog2(MAX_FRAME_BYTES);
  localparam int BPOS_W  = ADDR_W + 1;
  localparam int TAB_W   = $clog2(TABLE_LEN);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } dasm_cmd_e;

  localparam logic [LEVEL_W-1:0] RAMP_TAB [TABLE_LEN] = '{
    7'd0,  7'd8,  7'd16, 7'd23, 7'd29, 7'd36, 7'd43, 7'd49, 7'd55, 7'd60,
    7'd65, 7'd70, 7'd74, 7'd78, 7'd81, 7'd84, 7'd86, 7'd88, 7'd89, 7'd90,
    7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90,
    7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90
  };

  localparam logic [LEVEL_W-1:0] DIP_TAB [TABLE_LEN] = '{
    7'd90, 7'd89, 7'd88, 7'd86, 7'd84, 7'd81, 7'd78, 7'd74, 7'd70, 7'd65,
    7'd60, 7'd55, 7'd49, 7'd43, 7'd36, 7'd29, 7'd23, 7'd16, 7'd8,  7'd0,
    7'd0,  7'd8,  7'd16, 7'd23, 7'd29, 7'd36, 7'd43, 7'd49, 7'd55, 7'd60,
    7'd65, 7'd70, 7'd74, 7'd78, 7'd81, 7'd84, 7'd86, 7'd88, 7'd89, 7'd90
  };

  function automatic logic [LEVEL_W-1:0] ramp_at(input logic [POS_W-1:0] idx);
    logic [TAB_W-1:0] i;
    i = (int'(idx) >= TABLE_LEN) ? TAB_W'(TABLE_LEN - 1) : TAB_W'(idx);
    return RAMP_TAB[i];
  endfunction

  function automatic logic [LEVEL_W-1:0] dip_at(input logic [POS_W-1:0] idx);
    logic [TAB_W-1:0] i;
    i = (int'(idx) >= TABLE_LEN) ? TAB_W'(TABLE_LEN - 1) : TAB_W'(idx);
    return DIP_TAB[i];
  endfunction

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } dasm_wr_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pa_level;
    logic               phase_pin;
    logic               radio_on_pulse;
    logic               radio_off_pulse;
    logic               busy_res;
  } dasm_res_t;

endpackage

`default_nettype wire

// ----- sv/dasm_if.sv -----
// Valid/ready channel interfaces for command beats and result beats.
// Depends on dasm_pkg for field widths.
`default_nettype none

interface dasm_in_if
  import dasm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] byte_value;
  logic [SLOT_W-1:0] byte_slot;
  logic [LEN_W-1:0]  frame_bytes;

  modport source (output valid, cmd, byte_value, byte_slot, frame_bytes, input ready);
  modport sink   (input valid, cmd, byte_value, byte_slot, frame_bytes, output ready);
endinterface

interface dasm_out_if
  import dasm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] pa_level;
  logic               phase_pin;
  logic               radio_on_pulse;
  logic               radio_off_pulse;
  logic               busy_res;

  modport source (output valid, pa_level, phase_pin, radio_on_pulse, radio_off_pulse,
                  busy_res, input ready);
  modport sink   (input valid, pa_level, phase_pin, radio_on_pulse, radio_off_pulse,
                  busy_res, output ready);
endinterface

`default_nettype wire

// ----- sv/dbpsk_amplitude_shaped_modulator.sv -----
// Amplitude-shaped DBPSK modulator: one command beat in, one result beat out per cycle.
// The block takes one beat every cycle while the result register is free or being
// drained; its result shows in the output register the cycle after acceptance. A tick
// looks up one ramp or dip profile entry; the current frame byte is kept prefetched from
// the 32-byte store (one write and one registered read port, same-address writes
// forwarded), so no tick waits on the memory. The store has no clearing pass after reset.
// Depends on dasm_pkg, dasm_if, dasm_store and dasm_seq.
`default_nettype none

module dbpsk_amplitude_shaped_modulator
  import dasm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dasm_in_if.sink   in_i,
  dasm_out_if.source out_o
);

  logic              accept;
  logic              out_valid_q;
  dasm_res_t         res, res_q;
  dasm_wr_t          wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  dasm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .cmd_i         (in_i.cmd),
    .byte_value_i  (in_i.byte_value),
    .byte_slot_i   (in_i.byte_slot),
    .frame_bytes_i (in_i.frame_bytes),
    .byte_data_i   (rd_data),
    .wr_o          (wr),
    .rd_addr_o     (rd_addr),
    .res_o         (res)
  );

  dasm_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.pa_level        = res_q.pa_level;
  assign out_o.phase_pin       = res_q.phase_pin;
  assign out_o.radio_on_pulse  = res_q.radio_on_pulse;
  assign out_o.radio_off_pulse = res_q.radio_off_pulse;
  assign out_o.busy_res        = res_q.busy_res;

endmodule

`default_nettype wire

// ----- sv/dasm_store.sv -----
// Frame byte store: one write port, one registered read port with write forwarding.
// Depends on dasm_pkg.
`default_nettype none

module dasm_store
  import dasm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire dasm_wr_t          wr_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [BYTE_W-1:0] rd_data_o
);

  logic [BYTE_W-1:0] mem_q [MAX_FRAME_BYTES];
  logic [BYTE_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // forward a same-cycle write so the read data tracks the store
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_q <= wr_i.data;
    end else begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ----- sv/dasm_seq.sv -----
// Transmission sequencer: phase state, profile/bit/byte counters, held level and pin.
// Depends on dasm_pkg; reads the current frame byte from dasm_store.
`default_nettype none

module dasm_seq
  import dasm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [BYTE_W-1:0] byte_value_i,
  input  wire logic [SLOT_W-1:0] byte_slot_i,
  input  wire logic [LEN_W-1:0]  frame_bytes_i,
  input  wire logic [BYTE_W-1:0] byte_data_i,
  output dasm_wr_t               wr_o,
  output logic      [ADDR_W-1:0] rd_addr_o,
  output dasm_res_t              res_o
);

  typedef enum logic [2:0] {
    ST_READY, ST_RAMP_UP, ST_BITS, ST_RAMP_DOWN, ST_STOP
  } state_e;

  state_e             state_q, state_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [2:0]         bit_q, bit_d;
  logic [ADDR_W-1:0]  byte_q, byte_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               pin_q, pin_d;
  logic               on, off;
  logic               pos_wrap;
  logic [BPOS_W-1:0]  byte_inc;

  assign pos_wrap = (pos_q == POS_W'(PROFILE_STEPS - 1));
  assign byte_inc = BPOS_W'(byte_q) + BPOS_W'(1);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    len_d   = len_q;
    level_d = level_q;
    pin_d   = pin_q;
    on      = 1'b0;
    off     = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.addr = ADDR_W'(byte_slot_i);
    wr_o.data = byte_value_i;
    if (accept_i) begin
      case (cmd_i)
        CMD_LOAD: begin
          wr_o.en = (state_q == ST_READY) && (int'(byte_slot_i) < MAX_FRAME_BYTES);
        end
        CMD_START: begin
          if (state_q == ST_READY) begin
            len_d   = (int'(frame_bytes_i) > MAX_FRAME_BYTES) ?
                      LEN_W'(MAX_FRAME_BYTES) : frame_bytes_i;
            pos_d   = '0;
            bit_d   = '0;
            byte_d  = '0;
            level_d = '0;
            state_d = ST_RAMP_UP;
            on      = 1'b1;
          end
        end
        CMD_TICK: begin
          case (state_q)
            ST_RAMP_UP: begin
              level_d = ramp_at(pos_q);
              pos_d   = pos_wrap ? '0 : pos_q + POS_W'(1);
              if (pos_wrap) begin
                state_d = ST_BITS;
              end
            end
            ST_BITS: begin
              if (!byte_data_i[~bit_q]) begin
                pin_d   = (pos_q == POS_W'(PROFILE_STEPS / 2));
                level_d = dip_at(pos_q);
              end else begin
                level_d = DIP_TAB[0];
              end
              pos_d = pos_wrap ? '0 : pos_q + POS_W'(1);
              if (pos_wrap) begin
                bit_d = bit_q + 3'd1;
                if (bit_q == 3'd7) begin
                  if (BPOS_W'(byte_inc) >= BPOS_W'(len_q)) begin
                    byte_d  = '0;
                    state_d = ST_RAMP_DOWN;
                  end else begin
                    byte_d = ADDR_W'(byte_inc);
                  end
                end
              end
            end
            ST_RAMP_DOWN: begin
              level_d = ramp_at(POS_W'(PROFILE_STEPS - 1) - pos_q);
              pos_d   = pos_wrap ? '0 : pos_q + POS_W'(1);
              if (pos_wrap) begin
                state_d = ST_STOP;
              end
            end
            ST_STOP: begin
              level_d = '0;
              state_d = ST_READY;
              off     = 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
      pos_q   <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      len_q   <= '0;
      level_q <= '0;
      pin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      len_q   <= len_d;
      level_q <= level_d;
      pin_q   <= pin_d;
    end
  end

  assign rd_addr_o             = byte_d;
  assign res_o.pa_level        = level_d;
  assign res_o.phase_pin       = pin_d;
  assign res_o.radio_on_pulse  = on;
  assign res_o.radio_off_pulse = off;
  assign res_o.busy_res        = (state_d != ST_READY);

endmodule

`default_nettype wire

// ----- sv/dasm_checker.sv -----
// Port-level checks on result beats of the modulator, bound to the top level.
// Depends on dasm_pkg and the top level's channel ports.
`default_nettype none

module dasm_checker
  import dasm_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [LEVEL_W-1:0] pa_level_i,
  input wire logic               radio_on_pulse_i,
  input wire logic               radio_off_pulse_i,
  input wire logic               busy_res_i
);

  a_on_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && radio_on_pulse_i |-> busy_res_i && pa_level_i == '0)
    else $error("start beat not busy or level not zero");

  a_off_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && radio_off_pulse_i |-> !busy_res_i && pa_level_i == '0)
    else $error("stop beat still busy or level not zero");

  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |-> pa_level_i == '0 && !radio_on_pulse_i)
    else $error("idle beat drives amplifier");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pa_level_i))
    else $error("stalled result beat dropped or changed");

endmodule

bind dbpsk_amplitude_shaped_modulator dasm_checker u_dasm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .pa_level_i        (out_o.pa_level),
  .radio_on_pulse_i  (out_o.radio_on_pulse),
  .radio_off_pulse_i (out_o.radio_off_pulse),
  .busy_res_i        (out_o.busy_res)
);

`default_nettype wire
